[hw/rtl/cdq_pkg.sv]
// Shared constants and types for the circular deque.
package cdq_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned CAP_RESET  = 64;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned OP_W       = 3;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

  typedef struct packed {
    logic load;
    logic exec;
    logic read;
  } cdq_cmd_t;

endpackage

[hw/rtl/cdq_if.sv]
// Request, response and configuration channel interfaces.
interface cdq_req_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if import cdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

[hw/rtl/cdq_ctrl.sv]
// Sequencing state machine for the circular deque.
module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     rsp_ready_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  output cdq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_e;

  state_e state_q;
  logic   req_ready_q;
  logic   rsp_valid_q;
  logic   req_fire;

  assign req_fire    = req_valid_i & req_ready_q;
  assign req_ready_o = req_ready_q;
  assign rsp_valid_o = rsp_valid_q;

  assign cmd_o.load = req_fire;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign cmd_o.read = (state_q == S_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_ready_q <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            state_q     <= S_EXEC;
            req_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q <= S_READ;
        end
        S_READ: begin
          state_q     <= S_RESP;
          rsp_valid_q <= 1'b1;
        end
        S_RESP: begin
          // hold the result until the receiver takes the beat
          if (rsp_ready_i) begin
            state_q     <= S_IDLE;
            rsp_valid_q <= 1'b0;
            req_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          req_ready_q <= 1'b1;
          rsp_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

[hw/rtl/cdq_dpath.sv]
// Ring storage, pointers and result registers for the circular deque.
module cdq_dpath import cdq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cdq_cmd_t                 cmd_i,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [WORD_W-1:0] value_i,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_capacity_i,
  output logic                     ok_o,
  output logic signed [WORD_W-1:0] front_value_o,
  output logic signed [WORD_W-1:0] rear_value_o,
  output logic                     is_empty_o,
  output logic                     is_full_o
);

  // Ring position base + off, with off below DEPTH
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  logic signed [WORD_W-1:0] mem [DEPTH];

  logic [OP_W-1:0]          op_q;
  logic signed [WORD_W-1:0] value_q;
  logic [CAP_W-1:0]         cap_q;
  logic [ADDR_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     ok_q, ok_d;
  logic signed [WORD_W-1:0] front_q, rear_q;
  logic                     empty_q, full_q;

  logic [CMP_W-1:0]         eff_cap;
  logic                     full_now, empty_now;
  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic [ADDR_W-1:0]        rear_addr;
  logic [ADDR_W-1:0]        head_dec;

  // saturate capacity at the ring depth
  assign eff_cap   = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
  assign full_now  = CMP_W'(count_q) >= eff_cap;
  assign empty_now = (count_q == '0);
  assign head_dec  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
  assign rear_addr = ring_add(head_q, count_q - CNT_W'(1));

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    ok_d    = ok_q;
    we      = 1'b0;
    waddr   = head_q;
    if (cfg_we_i) begin
      head_d  = '0;
      count_d = '0;
    end else if (cmd_i.exec) begin
      ok_d = 1'b1;
      case (op_q)
        OP_PUSH_FRONT: begin
          if (full_now) begin
            ok_d = 1'b0;
          end else begin
            head_d  = head_dec;
            waddr   = head_dec;
            we      = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        OP_PUSH_REAR: begin
          if (full_now) begin
            ok_d = 1'b0;
          end else begin
            waddr   = ring_add(head_q, count_q);
            we      = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty_now) begin
            ok_d = 1'b0;
          end else begin
            head_d  = ring_add(head_q, CNT_W'(1));
            count_d = count_q - 1'b1;
          end
        end
        OP_POP_REAR: begin
          if (empty_now) begin
            ok_d = 1'b0;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          ok_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_W'(CAP_RESET);
      head_q  <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_capacity_i;
      end
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      value_q <= value_i;
    end
    ok_q <= ok_d;
    if (we) begin
      mem[waddr] <= value_q;
    end
    if (cmd_i.read) begin
      front_q <= mem[head_q];
      rear_q  <= mem[rear_addr];
      empty_q <= empty_now;
      full_q  <= full_now;
    end
  end

  assign ok_o          = ok_q;
  assign front_value_o = empty_q ? EMPTY_WORD : front_q;
  assign rear_value_o  = empty_q ? EMPTY_WORD : rear_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

endmodule

[hw/rtl/circular_deque.sv]
// Circular deque top level: bounded double-ended queue of 32-bit words.
//
// Channels: req_i carries an opcode (push front, push rear, pop front,
// pop rear, probe) and a value; rsp_o returns one beat per request with
// ok, the front and rear words (-1 when empty) and the empty/full flags
// after the operation. cfg_i writes the capacity register and empties the
// deque; write it only while no request is outstanding.
// Timing: one request at a time. An accepted request passes through the
// execute and storage-read states before its response turns valid, and
// the next request is taken only once the receiver has taken that
// response; the two-port storage read follows the pointer update.
// Reset: the deque is empty, capacity is 64, req_i.ready is high. Storage
// contents are not cleared; only words written by a push are ever reported.
// Stall: while rsp_o is held by the receiver, the response beat stays
// stable and req_i.ready stays low.
module circular_deque import cdq_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  cdq_req_if.sink        req_i,
  cdq_rsp_if.source      rsp_o,
  cdq_cfg_if.sink        cfg_i
);

  cdq_cmd_t cmd;
  logic     cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid & cfg_i.ready;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  cdq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (req_i.opcode),
    .value_i        (req_i.value),
    .cfg_we_i       (cfg_we),
    .cfg_capacity_i (cfg_i.capacity),
    .ok_o           (rsp_o.ok),
    .front_value_o  (rsp_o.front_value),
    .rear_value_o   (rsp_o.rear_value),
    .is_empty_o     (rsp_o.is_empty),
    .is_full_o      (rsp_o.is_full)
  );

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_o.valid && req_i.ready))
    else $error("request taken while a response is pending");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> ##3 rsp_o.valid)
    else $error("response not valid three cycles after request");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.is_empty) |->
      (rsp_o.front_value == EMPTY_WORD && rsp_o.rear_value == EMPTY_WORD))
    else $error("empty deque reports a stored word");
`endif

endmodule

[tb/circular_deque_tb.sv]
// Self-checking testbench for the circular deque: directed, random and backpressure tests.
module circular_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam logic [OP_W-1:0] OP_PROBE       = 3'd4;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int LAT_CYCLES   = 4;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } deque_view_t;

  logic clk_i;
  logic rst_ni;

  cdq_req_if req_bus ();
  cdq_rsp_if rsp_bus ();
  cdq_cfg_if cfg_bus ();

  circular_deque dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  // Predicted deque contents and pointers
  logic signed [WORD_W-1:0] ring_q [DEPTH];
  logic [ADDR_W-1:0]        head_q;
  logic [CNT_W-1:0]         count_q;
  logic [CAP_W-1:0]         cap_q;

  deque_view_t pending_views [$];

  int  errors;
  int  sent_total;
  int  cfg_writes;
  int  full_hits;
  int  empty_hits;
  int  refusals;
  int  cycles;
  int  hold_request;
  bit  src_gaps_on;
  bit  sink_stall_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d responses outstanding", $time, pending_views.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Response sink: random stalls, plus long hold-offs on request
  initial begin
    int n;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        rsp_bus.ready = 1'b0;
        n = hold_request;
        hold_request = 0;
        repeat (n) @(negedge clk_i);
      end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
        rsp_bus.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      rsp_bus.ready = 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic signed [WORD_W-1:0] want,
                               input logic signed [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)",
               $time, name, want, want, got, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    deque_view_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual ok=%0b front=%0d rear=%0d",
                 $time, rsp_bus.ok, rsp_bus.front_value, rsp_bus.rear_value);
        errors++;
      end else begin
        want = pending_views.pop_front();
        compare_field("ok", WORD_W'(want.ok), WORD_W'(rsp_bus.ok));
        compare_field("front_value", want.front_value, rsp_bus.front_value);
        compare_field("rear_value", want.rear_value, rsp_bus.rear_value);
        compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(rsp_bus.is_empty));
        compare_field("is_full", WORD_W'(want.is_full), WORD_W'(rsp_bus.is_full));
      end
    end
  end

  function automatic deque_view_t apply_deque_op(input logic [OP_W-1:0] op,
                                                 input logic signed [WORD_W-1:0] word);
    deque_view_t       view;
    int unsigned       limit;
    logic [ADDR_W-1:0] slot;
    logic              was_full;
    logic              was_empty;
    limit = (cap_q > DEPTH) ? DEPTH : cap_q;
    was_full = (count_q >= limit);
    was_empty = (count_q == 0);
    view.ok = 1'b1;
    case (op)
      OP_PUSH_FRONT: begin
        if (was_full) begin
          view.ok = 1'b0;
        end else begin
          head_q = head_q - 1'b1;
          ring_q[head_q] = word;
          count_q = count_q + 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        if (was_full) begin
          view.ok = 1'b0;
        end else begin
          slot = head_q + count_q[ADDR_W-1:0];
          ring_q[slot] = word;
          count_q = count_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (was_empty) begin
          view.ok = 1'b0;
        end else begin
          head_q = head_q + 1'b1;
          count_q = count_q - 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (was_empty) begin
          view.ok = 1'b0;
        end else begin
          count_q = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
    view.is_empty = (count_q == 0);
    view.is_full = (count_q >= limit);
    if (view.is_empty) begin
      view.front_value = EMPTY_WORD;
      view.rear_value = EMPTY_WORD;
    end else begin
      slot = head_q + count_q[ADDR_W-1:0] - 1'b1;
      view.front_value = ring_q[head_q];
      view.rear_value = ring_q[slot];
    end
    if (view.is_full) full_hits++;
    if (view.is_empty) empty_hits++;
    if (!view.ok) refusals++;
    return view;
  endfunction

  // Callers start and end on a falling edge
  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] word);
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      req_bus.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    req_bus.opcode = op;
    req_bus.value = word;
    req_bus.valid = 1'b1;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    pending_views.push_back(apply_deque_op(op, word));
    sent_total++;
    @(negedge clk_i);
    req_bus.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_views.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (LAT_CYCLES) @(negedge clk_i);
    cfg_bus.capacity = cap;
    cfg_bus.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cap_q = cap;
    head_q = '0;
    count_q = '0;
    cfg_writes++;
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic logic [OP_W-1:0] pick_op(input int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return OP_W'($urandom_range(OP_PROBE, OP_SPARE_LAST));
    if (roll < 4 + push_pct) return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(WORD_W-1){1'b1}}};
      1: return {1'b1, {(WORD_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_chunk(input int n, input int push_pct);
    repeat (n) send_op(pick_op(push_pct), pick_word());
  endtask

  task automatic test_reset_view();
    send_op(OP_PROBE, pick_word());
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_REAR, '0);
    for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++) send_op(OP_W'(o), '1);
  endtask

  task automatic test_push_pop_extremes();
    send_op(OP_PUSH_FRONT, {1'b0, {(WORD_W-1){1'b1}}});
    send_op(OP_PUSH_REAR, {1'b1, {(WORD_W-1){1'b0}}});
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_PUSH_REAR, '1);
    send_op(OP_PROBE, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_REAR, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_REAR, '0);
    send_op(OP_POP_FRONT, '0);
  endtask

  task automatic test_capacity_edges();
    cfg_write(7'd1);
    send_op(OP_PUSH_REAR, 32'sh5A5A_5A5A);
    send_op(OP_PUSH_FRONT, 32'sh1234_5678);
    send_op(OP_POP_REAR, '0);
    // zero capacity: empty and full at once, everything refused
    cfg_write(7'd0);
    send_op(OP_PUSH_FRONT, 32'sh0000_0001);
    send_op(OP_PUSH_REAR, 32'sh0000_0002);
    send_op(OP_POP_FRONT, '0);
    cfg_write(7'd2);
    send_op(OP_PUSH_FRONT, 32'shA5A5_A5A5);
    send_op(OP_PUSH_REAR, 32'sh0F0F_0F0F);
    send_op(OP_PUSH_REAR, 32'shFFFF_0000);
    // rewriting the same value still empties
    cfg_write(7'd2);
    send_op(OP_PROBE, '0);
  endtask

  task automatic test_random_mix();
    logic [CAP_W-1:0] caps [11];
    int span;
    caps = '{7'd64, 7'd1, 7'd5, 7'd127, 7'd0, 7'd2, 7'd16, 7'd3, 7'd40, 7'd65, 7'd7};
    foreach (caps[i]) begin
      src_gaps_on = ($urandom_range(0, 3) != 0);
      sink_stall_on = ($urandom_range(0, 3) != 0);
      cfg_write(caps[i]);
      span = (caps[i] > DEPTH) ? DEPTH : caps[i];
      span = span + span / 4 + 8;
      // fill to capacity, drain to empty, then a mixed stretch
      run_chunk(span, 92);
      run_chunk(span, 4);
      run_chunk(24, 50);
    end
  endtask

  task automatic test_backpressure();
    src_gaps_on = 1'b0;
    wait_drained();
    hold_request = HOLD_CYCLES;
    run_chunk(12, 70);
    wait_drained();
  endtask

  task automatic test_streaming();
    src_gaps_on = 1'b0;
    sink_stall_on = 1'b0;
    cfg_write(7'd48);
    run_chunk(60, 92);
    run_chunk(90, 30);
  endtask

  initial begin
    errors = 0;
    sent_total = 0;
    cfg_writes = 0;
    full_hits = 0;
    empty_hits = 0;
    refusals = 0;
    hold_request = 0;
    src_gaps_on = 1'b1;
    sink_stall_on = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.opcode = OP_PROBE;
    req_bus.value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.capacity = '0;
    rst_ni = 1'b0;
    cap_q = CAP_RESET;
    head_q = '0;
    count_q = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_view();
    test_push_pop_extremes();
    test_capacity_edges();
    test_random_mix();
    test_backpressure();
    test_streaming();

    wait_drained();
    repeat (2 * LAT_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests over %0d capacity writes, including zero and saturating sizes.",
             sent_total, cfg_writes);
    $display("Saw %0d full, %0d empty and %0d refused responses; %0d mismatches.",
             full_hits, empty_hits, refusals, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
